>>> rtl/mh_pkg.sv
// Shared types, constants and the arctangent table for the magnetometer heading block.
// No dependencies; compiled first.
package mh_pkg;

    // Readings are 16 bits, scaled by 256; CORDIC gain and the
    // quarter-turn pre-rotation need a little headroom on top.
    localparam int READING_W = 16;
    localparam int VEC_W     = 27;
    localparam int DECL_W    = 15;
    localparam int HEAD_W    = 15;
    localparam int SUM_W     = 18;
    localparam int TABLE_LEN = 24;
    localparam int TURN_UNITS = 23040;
    localparam int DECL_LIMIT = 11520;

    // arctan(2^-i) at 2^32 units per turn
    localparam longint ATAN_TURN32 [TABLE_LEN] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10680862, 5340757, 2670675, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    // Payload that travels down the CORDIC pipeline
    typedef struct packed {
        logic [READING_W-1:0]    x;
        logic [READING_W-1:0]    y;
        logic [READING_W-1:0]    z;
        logic                    zero;
        logic signed [VEC_W-1:0] a;
        logic signed [VEC_W-1:0] b;
    } mh_item_t;

    // Table entry rounded half up to the given angle resolution
    function automatic longint atan_step(input int idx, input int angle_bits);
        longint r;
        r = (ATAN_TURN32[idx] + (64'sd1 <<< (31 - angle_bits))) >>> (32 - angle_bits);
        return r;
    endfunction

endpackage

>>> rtl/mh_channels_if.sv
// Valid/ready channel interfaces for the burst input and the heading result.
// Depends on mh_pkg for field widths.
interface mh_in_if
    import mh_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [7:0] x_high;
    logic [7:0] x_low;
    logic [7:0] z_high;
    logic [7:0] z_low;
    logic [7:0] y_high;
    logic [7:0] y_low;

    modport source (output valid, x_high, x_low, z_high, z_low, y_high, y_low,
                    input ready);
    modport sink   (input valid, x_high, x_low, z_high, z_low, y_high, y_low,
                    output ready);
endinterface

interface mh_out_if
    import mh_pkg::*;
;
    logic                        valid;
    logic                        ready;
    logic signed [READING_W-1:0] field_x;
    logic signed [READING_W-1:0] field_y;
    logic signed [READING_W-1:0] field_z;
    logic [HEAD_W-1:0]           heading;

    modport source (output valid, field_x, field_y, field_z, heading, input ready);
    modport sink   (input valid, field_x, field_y, field_z, heading, output ready);
endinterface

>>> rtl/magnetometer_heading.sv
// Compass heading from a six-byte magnetometer burst, top level.
// Depends on mh_pkg, mh_channels_if and mh_cordic_stage.
//
// Usage: samples carries one burst per item (X high/low, Z high/low,
// Y high/low). result returns the signed x, y, z readings and the heading
// atan2(x, y) plus declination, wrapped into 0..23040 (1/64 degree).
// The declination register is written through cfg_wr_en/cfg_wr_data; the
// user must write it only while the block is idle (the block does not
// enforce this). Values beyond +-11520 are clamped on write. The accepting
// edge loads the input stage with the quarter-turn pre-rotation; the item
// then passes one stage per CORDIC iteration, one multiply stage and one
// output stage, whose register makes the result valid. CORDIC_STEPS is
// capped at 24. Throughput: one item per cycle while result is not stalled.
// When result stalls, the whole pipeline holds and samples.ready drops in
// the same cycle; nothing is lost or repeated. All stages share one enable,
// so while the output waits no item is taken or advanced, even into stages
// that are empty.
// Reset empties the pipeline and sets the declination to 0.
module magnetometer_heading
    import mh_pkg::*;
#(
    parameter int ANGLE_BITS   = 16,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [DECL_W-1:0] cfg_wr_data,
    mh_in_if.sink             samples,
    mh_out_if.source          result
);

    localparam int NSTEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int ACC_W  = ANGLE_BITS + 1;
    localparam int PROD_W = ACC_W + 16;
    localparam logic signed [ACC_W-1:0]  QUARTER = ACC_W'(1) <<< (ANGLE_BITS - 2);
    localparam logic signed [15:0]       TURN_MUL = 16'(TURN_UNITS);
    localparam logic signed [PROD_W-1:0] ROUND = PROD_W'(1) <<< (ANGLE_BITS - 1);
    localparam logic signed [SUM_W-1:0]  TURN_S = SUM_W'(TURN_UNITS);
    localparam logic signed [DECL_W-1:0] DECL_HI = DECL_W'(DECL_LIMIT);
    localparam logic signed [DECL_W-1:0] DECL_LO = -DECL_W'(DECL_LIMIT);

    logic en;

    // Declination register, clamped on write
    logic signed [DECL_W-1:0] decl_reg;
    logic signed [DECL_W-1:0] decl_next;

    always_comb
    begin
        priority if ($signed(cfg_wr_data) > DECL_HI)
            decl_next = DECL_HI;
        else if ($signed(cfg_wr_data) < DECL_LO)
            decl_next = DECL_LO;
        else
            decl_next = $signed(cfg_wr_data);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decl_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            decl_reg <= decl_next;
        end
    end

    // Global stall: every stage moves when the output register can take data
    logic out_valid_reg;
    assign en            = !out_valid_reg || result.ready;
    assign samples.ready = en;

    // Input stage: join bytes and pre-rotate the left half plane
    logic                    in_valid_reg;
    mh_item_t                in_item_reg;
    mh_item_t                in_item_next;
    logic signed [ACC_W-1:0] in_acc_reg;
    logic signed [ACC_W-1:0] in_acc_next;
    logic signed [VEC_W-1:0] ya;
    logic signed [VEC_W-1:0] xb;

    always_comb
    begin
        in_item_next.x    = {samples.x_high, samples.x_low};
        in_item_next.y    = {samples.y_high, samples.y_low};
        in_item_next.z    = {samples.z_high, samples.z_low};
        in_item_next.zero = (in_item_next.x == '0) && (in_item_next.y == '0);
        ya = VEC_W'($signed({samples.y_high, samples.y_low, 8'h00}));
        xb = VEC_W'($signed({samples.x_high, samples.x_low, 8'h00}));
        in_item_next.a = ya;
        in_item_next.b = xb;
        in_acc_next    = '0;
        if (ya[VEC_W-1])
        begin
            if (!xb[VEC_W-1])
            begin
                in_item_next.a = xb;
                in_item_next.b = -ya;
                in_acc_next    = QUARTER;
            end
            else
            begin
                in_item_next.a = -xb;
                in_item_next.b = ya;
                in_acc_next    = -QUARTER;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            in_valid_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_item_reg <= in_item_next;
            in_acc_reg  <= in_acc_next;
        end
    end

    // CORDIC iteration stages
    logic [NSTEPS-1:0]       pipe_valid;
    mh_item_t                pipe_item [NSTEPS];
    logic signed [ACC_W-1:0] pipe_acc  [NSTEPS];

    genvar k;
    generate
        for (k = 0; k < NSTEPS; k++)
        begin : g_step
            if (k == 0)
            begin : g_first
                mh_cordic_stage #(
                    .ACC_W      (ACC_W),
                    .SHIFT      (k),
                    .STEP_ANGLE (int'(atan_step(k, ANGLE_BITS)))
                ) u_stage (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .en        (en),
                    .in_valid  (in_valid_reg),
                    .in_item   (in_item_reg),
                    .in_acc    (in_acc_reg),
                    .out_valid (pipe_valid[k]),
                    .out_item  (pipe_item[k]),
                    .out_acc   (pipe_acc[k])
                );
            end
            else
            begin : g_next
                mh_cordic_stage #(
                    .ACC_W      (ACC_W),
                    .SHIFT      (k),
                    .STEP_ANGLE (int'(atan_step(k, ANGLE_BITS)))
                ) u_stage (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .en        (en),
                    .in_valid  (pipe_valid[k-1]),
                    .in_item   (pipe_item[k-1]),
                    .in_acc    (pipe_acc[k-1]),
                    .out_valid (pipe_valid[k]),
                    .out_item  (pipe_item[k]),
                    .out_acc   (pipe_acc[k])
                );
            end
        end
    endgenerate

    // Multiply stage: angle to 1/64 degree, zero vector forced to 0
    logic                     mul_valid_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  ang;
    logic [READING_W-1:0]     mul_x_reg;
    logic [READING_W-1:0]     mul_y_reg;
    logic [READING_W-1:0]     mul_z_reg;

    assign ang = pipe_item[NSTEPS-1].zero ? '0 : pipe_acc[NSTEPS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            mul_valid_reg <= pipe_valid[NSTEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= PROD_W'(ang) * PROD_W'(TURN_MUL);
            mul_x_reg <= pipe_item[NSTEPS-1].x;
            mul_y_reg <= pipe_item[NSTEPS-1].y;
            mul_z_reg <= pipe_item[NSTEPS-1].z;
        end
    end

    // Output stage: round, add declination, wrap into one turn
    logic signed [PROD_W-1:0] deg_full;
    logic signed [SUM_W-1:0]  sum0;
    logic signed [SUM_W-1:0]  sum1;
    logic signed [SUM_W-1:0]  sum2;
    logic [READING_W-1:0]     out_x_reg;
    logic [READING_W-1:0]     out_y_reg;
    logic [READING_W-1:0]     out_z_reg;
    logic [HEAD_W-1:0]        heading_reg;

    always_comb
    begin
        deg_full = (prod_reg + ROUND) >>> ANGLE_BITS;
        sum0     = SUM_W'(deg_full) + SUM_W'(decl_reg);
        sum1     = sum0[SUM_W-1] ? (sum0 + TURN_S) : sum0;
        sum2     = (sum1 > TURN_S) ? (sum1 - TURN_S) : sum1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_x_reg   <= mul_x_reg;
            out_y_reg   <= mul_y_reg;
            out_z_reg   <= mul_z_reg;
            heading_reg <= sum2[HEAD_W-1:0];
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.field_x = $signed(out_x_reg);
    assign result.field_y = $signed(out_y_reg);
    assign result.field_z = $signed(out_z_reg);
    assign result.heading = heading_reg;

    // An accepted item always lands in the input stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready) |=> in_valid_reg)
    else $error("accepted item missing from input stage");

    // A stall freezes every valid bit in the pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable({in_valid_reg, pipe_valid, mul_valid_reg, out_valid_reg}))
    else $error("pipeline moved during a stall");

    // A new result only comes from the multiply stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(mul_valid_reg))
    else $error("result appeared without a source item");

endmodule

>>> rtl/mh_cordic_stage.sv
// One registered CORDIC vectoring iteration with its valid bit.
// Depends on mh_pkg for the item type.
module mh_cordic_stage
    import mh_pkg::*;
#(
    parameter int ACC_W      = 17,
    parameter int SHIFT      = 0,
    parameter int STEP_ANGLE = 8192
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  mh_item_t                in_item,
    input  logic signed [ACC_W-1:0] in_acc,
    output logic                    out_valid,
    output mh_item_t                out_item,
    output logic signed [ACC_W-1:0] out_acc
);

    localparam logic signed [ACC_W-1:0] STEP = ACC_W'(STEP_ANGLE);

    logic                    valid_reg;
    mh_item_t                item_reg;
    mh_item_t                item_next;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [VEC_W-1:0] da;
    logic signed [VEC_W-1:0] db;

    // Rotate toward the axis by the sign of the y part
    always_comb
    begin
        da        = in_item.b >>> SHIFT;
        db        = in_item.a >>> SHIFT;
        item_next = in_item;
        if (!in_item.b[VEC_W-1])
        begin
            item_next.a = in_item.a + da;
            item_next.b = in_item.b - db;
            acc_next    = in_acc + STEP;
        end
        else
        begin
            item_next.a = in_item.a - da;
            item_next.b = in_item.b + db;
            acc_next    = in_acc - STEP;
        end
    end

    // Advance valid bit with the stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // Hold payload while stalled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
            acc_reg  <= acc_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign out_acc   = acc_reg;

endmodule
